// ===== rtl/core/ktl_pkg.sv =====
// Keyword token lexer: shared types, token kind codes and character constants.
// No dependencies; used by every module of the lexer core.
package ktl_pkg;

  localparam int LINE_LENGTH = 256;
  localparam int POS_CAP_INT = ((LINE_LENGTH - 1) < 255) ? (LINE_LENGTH - 1) : 255;
  localparam logic [7:0] POS_CAP = 8'(POS_CAP_INT);

  localparam logic [4:0] KIND_NONE   = 5'd0;
  localparam logic [4:0] KIND_IF     = 5'd1;
  localparam logic [4:0] KIND_WHILE  = 5'd2;
  localparam logic [4:0] KIND_DO     = 5'd3;
  localparam logic [4:0] KIND_ELSE   = 5'd4;
  localparam logic [4:0] KIND_FOR    = 5'd5;
  localparam logic [4:0] KIND_IDENT  = 5'd6;
  localparam logic [4:0] KIND_CONST  = 5'd7;
  localparam logic [4:0] KIND_LT     = 5'd8;
  localparam logic [4:0] KIND_LE     = 5'd9;
  localparam logic [4:0] KIND_GT     = 5'd10;
  localparam logic [4:0] KIND_GE     = 5'd11;
  localparam logic [4:0] KIND_ASSIGN = 5'd12;
  localparam logic [4:0] KIND_EQ     = 5'd13;
  localparam logic [4:0] KIND_LPAREN = 5'd14;
  localparam logic [4:0] KIND_RPAREN = 5'd15;
  localparam logic [4:0] KIND_SEMI   = 5'd16;
  localparam logic [4:0] KIND_PLUS   = 5'd17;
  localparam logic [4:0] KIND_MINUS  = 5'd18;
  localparam logic [4:0] KIND_ERROR  = 5'd19;

  localparam logic [7:0] CH_EOL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_D      = 8'h64;
  localparam logic [7:0] CH_E      = 8'h65;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_H      = 8'h68;
  localparam logic [7:0] CH_I      = 8'h69;
  localparam logic [7:0] CH_L      = 8'h6C;
  localparam logic [7:0] CH_O      = 8'h6F;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_S      = 8'h73;
  localparam logic [7:0] CH_W      = 8'h77;

  typedef struct packed {
    logic eol;
    logic space;
    logic alpha;
    logic digit;
    logic under;
    logic delim;
    logic const_end;
  } ktl_class_t;

  typedef struct packed {
    logic [7:0] code;
    ktl_class_t cls;
    logic [7:0] pos;
  } ktl_entry_t;

endpackage

// ===== rtl/core/ktl_front.sv =====
// Keyword token lexer front: accepts characters, classifies them and tracks
// the line position. Depends on ktl_pkg.
module ktl_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [7:0]         char_code_i,
  input  logic               full_i,
  output logic               in_stall_o,
  output logic               push_o,
  output ktl_pkg::ktl_entry_t entry_o
);

  logic [7:0] pos_q, pos_d;
  logic [7:0] c;

  assign c          = char_code_i;
  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    entry_o.code          = c;
    entry_o.pos           = pos_q;
    entry_o.cls.eol       = (c == ktl_pkg::CH_EOL);
    entry_o.cls.space     = (c == ktl_pkg::CH_SPACE);
    entry_o.cls.alpha     = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    entry_o.cls.digit     = (c >= 8'h30 && c <= 8'h39);
    entry_o.cls.under     = (c == ktl_pkg::CH_UNDER);
    entry_o.cls.delim     = (c == ktl_pkg::CH_EOL) || (c == ktl_pkg::CH_LT) ||
                            (c == ktl_pkg::CH_GT) || (c == ktl_pkg::CH_LPAREN) ||
                            (c == ktl_pkg::CH_RPAREN) || (c == ktl_pkg::CH_SEMI) ||
                            (c == ktl_pkg::CH_EQ) || (c == ktl_pkg::CH_PLUS) ||
                            (c == ktl_pkg::CH_MINUS);
    entry_o.cls.const_end = (c == ktl_pkg::CH_LPAREN) || (c == ktl_pkg::CH_RPAREN) ||
                            (c == ktl_pkg::CH_LT) || (c == ktl_pkg::CH_GT) ||
                            (c == ktl_pkg::CH_EOL) || (c == ktl_pkg::CH_SEMI) ||
                            (c == ktl_pkg::CH_EQ);
  end

  // advance and saturate; restart at end of line
  always_comb begin
    pos_d = pos_q;
    if (push_o) begin
      if (c == ktl_pkg::CH_EOL) begin
        pos_d = '0;
      end else if (pos_q < ktl_pkg::POS_CAP) begin
        pos_d = pos_q + 8'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

// ===== rtl/core/ktl_queue.sv =====
// Keyword token lexer queue: small register FIFO of classified characters
// between front and back. Depends on ktl_pkg.
module ktl_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ktl_pkg::ktl_entry_t wdata_i,
  input  logic                pop_i,
  output ktl_pkg::ktl_entry_t rdata_o,
  output logic                full_o,
  output logic                nempty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ktl_pkg::ktl_entry_t mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          do_push, do_pop;

  assign full_o   = (count_q == CW'(DEPTH));
  assign nempty_o = (count_q != '0);
  assign do_push  = push_i && !full_o;
  assign do_pop   = pop_i && nempty_o;
  assign rdata_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ===== rtl/core/ktl_back.sv =====
// Keyword token lexer back: runs the token automaton on queued characters and
// holds the result register. Depends on ktl_pkg.
module ktl_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                nempty_i,
  input  ktl_pkg::ktl_entry_t entry_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [4:0]          token_kind_o,
  output logic [7:0]          start_pos_o,
  output logic [7:0]          end_pos_o,
  output logic                end_of_line_o
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_I, ST_IF, ST_W, ST_WH, ST_WHI, ST_WHIL, ST_WHILE, ST_D, ST_DO,
    ST_E, ST_EL, ST_ELS, ST_ELSE, ST_F, ST_FO, ST_FOR, ST_ID_START, ST_ID,
    ST_LT, ST_LE, ST_GT, ST_GE, ST_ASSIGN, ST_EQ, ST_CONST, ST_LPAREN,
    ST_RPAREN, ST_SEMI, ST_PLUS, ST_MINUS
  } lex_state_e;

  typedef struct packed {
    lex_state_e next;
    logic [4:0] emit;
    logic       rerun;
    logic       start;
    logic       err;
  } step_t;

  function automatic step_t lex_step(lex_state_e s, logic [7:0] c,
                                     ktl_pkg::ktl_class_t k);
    step_t      r;
    logic [7:0] want;
    lex_state_e adv;
    logic       word;
    r.next  = s;
    r.emit  = ktl_pkg::KIND_NONE;
    r.rerun = 1'b0;
    r.start = 1'b0;
    r.err   = 1'b0;
    want    = '0;
    adv     = ST_IDLE;
    word    = k.alpha || k.digit || k.under;
    unique case (s)
      ST_IDLE: begin
        if (c == ktl_pkg::CH_I) r.next = ST_I;
        else if (c == ktl_pkg::CH_W) r.next = ST_W;
        else if (c == ktl_pkg::CH_D) r.next = ST_D;
        else if (c == ktl_pkg::CH_E) r.next = ST_E;
        else if (c == ktl_pkg::CH_F) r.next = ST_F;
        else if (k.alpha || k.under) r.next = ST_ID_START;
        else if (c == ktl_pkg::CH_LT) r.next = ST_LT;
        else if (c == ktl_pkg::CH_GT) r.next = ST_GT;
        else if (c == ktl_pkg::CH_EQ) r.next = ST_ASSIGN;
        else if (k.digit) r.next = ST_CONST;
        else if (c == ktl_pkg::CH_LPAREN) r.next = ST_LPAREN;
        else if (c == ktl_pkg::CH_RPAREN) r.next = ST_RPAREN;
        else if (c == ktl_pkg::CH_SEMI) r.next = ST_SEMI;
        else if (c == ktl_pkg::CH_PLUS) r.next = ST_PLUS;
        else if (c == ktl_pkg::CH_MINUS) r.next = ST_MINUS;
        r.start = (r.next != ST_IDLE);
      end
      ST_I: begin
        want = ktl_pkg::CH_F; adv = ST_IF;
      end
      ST_W: begin
        want = ktl_pkg::CH_H; adv = ST_WH;
      end
      ST_WH: begin
        want = ktl_pkg::CH_I; adv = ST_WHI;
      end
      ST_WHI: begin
        want = ktl_pkg::CH_L; adv = ST_WHIL;
      end
      ST_WHIL: begin
        want = ktl_pkg::CH_E; adv = ST_WHILE;
      end
      ST_D: begin
        want = ktl_pkg::CH_O; adv = ST_DO;
      end
      ST_E: begin
        want = ktl_pkg::CH_L; adv = ST_EL;
      end
      ST_EL: begin
        want = ktl_pkg::CH_S; adv = ST_ELS;
      end
      ST_ELS: begin
        want = ktl_pkg::CH_E; adv = ST_ELSE;
      end
      ST_F: begin
        want = ktl_pkg::CH_O; adv = ST_FO;
      end
      ST_FO: begin
        want = ktl_pkg::CH_R; adv = ST_FOR;
      end
      ST_IF, ST_WHILE, ST_FOR: begin
        if (c == ktl_pkg::CH_LPAREN || k.eol) begin
          r.emit = (s == ST_IF) ? ktl_pkg::KIND_IF :
                   (s == ST_WHILE) ? ktl_pkg::KIND_WHILE : ktl_pkg::KIND_FOR;
        end else begin
          r.next  = ST_ID_START;
          r.rerun = 1'b1;
        end
      end
      ST_ELSE: begin
        if (c == ktl_pkg::CH_LBRACE || k.eol) begin
          r.emit = ktl_pkg::KIND_ELSE;
        end else begin
          r.next  = ST_ID_START;
          r.rerun = 1'b1;
        end
      end
      ST_DO: begin
        if (c == ktl_pkg::CH_LBRACE || k.space || k.eol || c == ktl_pkg::CH_LPAREN) begin
          r.emit = ktl_pkg::KIND_DO;
        end
      end
      ST_ID_START: begin
        if (word) begin
          r.next = ST_ID;
        end else if (k.delim) begin
          r.next  = ST_ID;
          r.rerun = 1'b1;
        end
      end
      ST_ID: begin
        if (k.delim) r.emit = ktl_pkg::KIND_IDENT;
      end
      ST_LT, ST_GT: begin
        if (c == ktl_pkg::CH_EQ) begin
          r.next = (s == ST_LT) ? ST_LE : ST_GE;
        end else if (word) begin
          r.emit = (s == ST_LT) ? ktl_pkg::KIND_LT : ktl_pkg::KIND_GT;
        end
      end
      ST_LE, ST_GE: begin
        if (word) r.emit = (s == ST_LE) ? ktl_pkg::KIND_LE : ktl_pkg::KIND_GE;
      end
      ST_ASSIGN: begin
        if (c == ktl_pkg::CH_EQ) r.next = ST_EQ;
        else r.emit = ktl_pkg::KIND_ASSIGN;
      end
      ST_EQ: begin
        if (k.alpha || k.digit) r.emit = ktl_pkg::KIND_EQ;
      end
      ST_CONST: begin
        if (k.alpha) begin
          r.err  = 1'b1;
          r.next = ST_IDLE;
        end else if (k.const_end) begin
          r.emit = ktl_pkg::KIND_CONST;
        end
      end
      ST_LPAREN: r.emit = ktl_pkg::KIND_LPAREN;
      ST_RPAREN: r.emit = ktl_pkg::KIND_RPAREN;
      ST_SEMI:   r.emit = ktl_pkg::KIND_SEMI;
      ST_PLUS:   r.emit = ktl_pkg::KIND_PLUS;
      ST_MINUS:  r.emit = ktl_pkg::KIND_MINUS;
      default:   r.next = ST_IDLE;
    endcase
    if (want != '0) begin
      if (c == want) begin
        r.next = adv;
      end else begin
        r.next  = ST_ID_START;
        r.rerun = 1'b1;
      end
    end
    if (r.emit != ktl_pkg::KIND_NONE) begin
      r.next  = ST_IDLE;
      r.rerun = 1'b1;
    end
    return r;
  endfunction

  lex_state_e state_q, state_d, chain_state;
  logic [7:0] tokst_q, tokst_d;
  logic       hold_q, hold_d;
  logic       out_valid_q, out_valid_d, eol_q, eol_d;
  logic [4:0] kind_q, kind_d, chain_kind;
  logic [7:0] spos_q, spos_d, epos_q, epos_d, prev_pos;
  logic       chain_err, chain_start, go;
  step_t      steps [4];

  assign pop_o = nempty_i && (!out_valid_q || !out_stall_i);
  assign prev_pos = (entry_i.pos == '0) ? '0 : entry_i.pos - 8'd1;

  // rerun the completing character through at most four automaton steps
  always_comb begin
    chain_state = state_q;
    chain_kind  = ktl_pkg::KIND_NONE;
    chain_err   = 1'b0;
    chain_start = 1'b0;
    go          = 1'b1;
    for (int i = 0; i < 4; i++) begin
      steps[i] = lex_step(chain_state, entry_i.code, entry_i.cls);
      if (go) begin
        chain_state = steps[i].next;
        if (steps[i].emit != ktl_pkg::KIND_NONE) chain_kind = steps[i].emit;
        chain_err   = chain_err || steps[i].err;
        chain_start = chain_start || steps[i].start;
        go          = steps[i].rerun;
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    tokst_d     = tokst_q;
    hold_d      = hold_q;
    out_valid_d = out_valid_q && out_stall_i;
    kind_d      = kind_q;
    spos_d      = spos_q;
    epos_d      = epos_q;
    eol_d       = eol_q;
    if (pop_o) begin
      out_valid_d = 1'b0;
      if (entry_i.cls.eol) begin
        out_valid_d = 1'b1;
        eol_d       = 1'b1;
        kind_d      = hold_q ? ktl_pkg::KIND_NONE : chain_kind;
        spos_d      = (kind_d == ktl_pkg::KIND_NONE) ? '0 : tokst_q;
        epos_d      = (kind_d == ktl_pkg::KIND_NONE) ? '0 : prev_pos;
        state_d     = ST_IDLE;
        tokst_d     = '0;
        hold_d      = 1'b0;
      end else if (!hold_q && !entry_i.cls.space) begin
        eol_d = 1'b0;
        if (chain_err) begin
          out_valid_d = 1'b1;
          kind_d      = ktl_pkg::KIND_ERROR;
          spos_d      = entry_i.pos;
          epos_d      = entry_i.pos;
          hold_d      = 1'b1;
          state_d     = ST_IDLE;
        end else begin
          state_d = chain_state;
          if (chain_start) tokst_d = entry_i.pos;
          if (chain_kind != ktl_pkg::KIND_NONE) begin
            out_valid_d = 1'b1;
            kind_d      = chain_kind;
            spos_d      = tokst_q;
            epos_d      = prev_pos;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tokst_q     <= '0;
      hold_q      <= 1'b0;
      out_valid_q <= 1'b0;
      kind_q      <= ktl_pkg::KIND_NONE;
      spos_q      <= '0;
      epos_q      <= '0;
      eol_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      tokst_q     <= tokst_d;
      hold_q      <= hold_d;
      out_valid_q <= out_valid_d;
      kind_q      <= kind_d;
      spos_q      <= spos_d;
      epos_q      <= epos_d;
      eol_q       <= eol_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign token_kind_o  = kind_q;
  assign start_pos_o   = spos_q;
  assign end_pos_o     = epos_q;
  assign end_of_line_o = eol_q;

endmodule

// ===== rtl/core/keyword_token_lexer_core.sv =====
// Keyword token lexer top level: front, request queue and automaton back.
// Depends on ktl_pkg, ktl_front, ktl_queue and ktl_back.
//
//   channel  dir  handshake              payload
//   in       in   in_valid_i/in_stall_o  char_code_i
//   out      out  out_valid_o/out_stall_i token_kind_o start_pos_o end_pos_o
//                                        end_of_line_o
//
// One request per cycle sustained while out_stall_i does not hold the result; an
// accepted request is first written into the queue, then the queue entry is read
// and the result register loaded.
// The automaton re-runs a completing character through up to four steps in a single combinational pass.
// Reset clears position, automaton state, queue and result valid.
// Output stalls fill the QUEUE_DEPTH-entry queue before in_stall_o rises.
module keyword_token_lexer_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] char_code_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [4:0] token_kind_o,
  output logic [7:0] start_pos_o,
  output logic [7:0] end_pos_o,
  output logic       end_of_line_o
);

  ktl_pkg::ktl_entry_t push_entry, pop_entry;
  logic push, pop, full, nempty;

  ktl_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .char_code_i (char_code_i),
    .full_i      (full),
    .in_stall_o  (in_stall_o),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  ktl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .wdata_i  (push_entry),
    .pop_i    (pop),
    .rdata_o  (pop_entry),
    .full_o   (full),
    .nempty_o (nempty)
  );

  ktl_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .nempty_i      (nempty),
    .entry_i       (pop_entry),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .token_kind_o  (token_kind_o),
    .start_pos_o   (start_pos_o),
    .end_pos_o     (end_pos_o),
    .end_of_line_o (end_of_line_o)
  );

endmodule

// ===== rtl/core/ktl_checker.sv =====
// Keyword token lexer port checker and its bind to the top level.
// Depends on ktl_pkg and keyword_token_lexer_core.
module ktl_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [4:0] token_kind_o,
  input logic [7:0] start_pos_o,
  input logic [7:0] end_pos_o,
  input logic       end_of_line_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(token_kind_o) &&
      $stable(start_pos_o) && $stable(end_pos_o) && $stable(end_of_line_o))
    else $error("stalled result changed");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> token_kind_o <= ktl_pkg::KIND_ERROR)
    else $error("token kind out of range");

  a_mid_line_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !end_of_line_o |-> token_kind_o != ktl_pkg::KIND_NONE)
    else $error("empty result inside a line");

  a_error_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_kind_o == ktl_pkg::KIND_ERROR |->
      start_pos_o == end_pos_o && !end_of_line_o)
    else $error("error result with mismatched positions");

  a_empty_eol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && end_of_line_o && token_kind_o == ktl_pkg::KIND_NONE |->
      start_pos_o == '0 && end_pos_o == '0)
    else $error("empty end of line with nonzero positions");

endmodule

bind keyword_token_lexer_core ktl_checker u_ktl_checker (.*);
